### hdl/xil_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xil_pkg
// Shared types, constants and decode functions for the x86 length decoder.
// ----------------------------------------------------------------------------
package xil_pkg;

  localparam int unsigned MaxInsnBytes = 15;
  localparam int unsigned PosW         = 4;

  localparam logic [7:0] OpszPrefix = 8'h66;
  localparam logic [7:0] PlusrMask  = 8'hF8;
  localparam logic [31:0] BranchLen = 32'd5;

  typedef enum logic [1:0] {
    KIND_NORM = 2'd0,
    KIND_JMP  = 2'd1,
    KIND_RET  = 2'd2,
    KIND_CALL = 2'd3
  } kind_e;

  // Decoded opcode attributes; hit is low when no table row matched
  typedef struct packed {
    logic  hit;
    logic  modrm;
    logic  i8;
    logic  i16;
    logic  i32;
    logic  rel;
    kind_e kind;
  } opinfo_t;

  // Stage 1 to stage 2 item
  typedef struct packed {
    logic [7:0][7:0] w_lo;
    logic [6:0][7:0] w_hi;
    logic [31:0]     src;
    logic [31:0]     dst;
    logic [PosW-1:0] pos;
    logic            opsz16;
    logic            fail;
  } s1_t;

  // Stage 2 to stage 3 item
  typedef struct packed {
    logic [7:0][7:0] w_lo;
    logic [6:0][7:0] w_hi;
    logic [31:0]     src;
    logic [31:0]     dst;
    logic [4:0]      len;
    logic [4:0]      modrm_off;
    logic [4:0]      imm_off;
    logic [2:0]      imm_size;
    logic [2:0]      reloc_size;
    logic            rel;
    kind_e           kind;
    logic            fail;
  } s2_t;

  function automatic logic is_prefix(input logic [7:0] b);
    unique case (b)
      8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65, 8'h66, 8'h67:
        is_prefix = 1'b1;
      default: is_prefix = 1'b0;
    endcase
  endfunction

  function automatic opinfo_t mk(input logic m, input logic a, input logic b,
                                 input logic c, input logic r, input kind_e k);
    opinfo_t o;
    o.hit = 1'b1;
    o.modrm = m; o.i8 = a; o.i16 = b; o.i32 = c; o.rel = r; o.kind = k;
    return o;
  endfunction

  // Match in table order; have_modrm tells whether a modrm byte is in the window.
  function automatic opinfo_t match_op(input logic [7:0] b, input logic [2:0] reg_f,
                                       input logic have_modrm);
    opinfo_t info;
    opinfo_t n;
    n    = mk(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, KIND_NORM);
    info = n;
    priority case (1'b1)
      b == 8'h04 || b == 8'h24 || b == 8'h0C || b == 8'h2C || b == 8'hA8 ||
      b == 8'h34 || b == 8'h6A: info = mk(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, KIND_NORM);
      b == 8'h05 || b == 8'h25 || b == 8'h3D || b == 8'h0D || b == 8'h2D ||
      b == 8'hA9 || b == 8'h35 || b == 8'h68 || (b >= 8'hA0 && b <= 8'hA3):
        info = mk(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, KIND_NORM);
      (b == 8'h80 || b == 8'h83) && have_modrm && reg_f != 3'd2 && reg_f != 3'd3 &&
        !(b == 8'h80 && reg_f == 3'd7):
        info = mk(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, KIND_NORM);
      b == 8'h81 && have_modrm && reg_f != 3'd2 && reg_f != 3'd3 && reg_f != 3'd7:
        info = mk(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, KIND_NORM);
      b <= 8'h03 || (b >= 8'h20 && b <= 8'h23) || b == 8'h39 || b == 8'h8D ||
      (b >= 8'h88 && b <= 8'h8C) || b == 8'h8E || (b >= 8'h08 && b <= 8'h0B) ||
      (b >= 8'h28 && b <= 8'h2B) || b == 8'h84 || b == 8'h85 ||
      (b >= 8'h30 && b <= 8'h33): info = mk(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, KIND_NORM);
      b == 8'hE8: info = mk(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, KIND_CALL);
      b == 8'hFF && have_modrm && reg_f == 3'd2:
        info = mk(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, KIND_CALL);
      b == 8'hFF && have_modrm && reg_f == 3'd4:
        info = mk(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, KIND_JMP);
      b == 8'hFF && have_modrm && (reg_f == 3'd1 || reg_f == 3'd6):
        info = mk(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, KIND_NORM);
      (b & PlusrMask) == 8'h48 || (b & PlusrMask) == 8'h58 ||
      (b & PlusrMask) == 8'h50: info = n;
      b == 8'hC8: info = mk(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, KIND_NORM);
      (b == 8'hD9 || b == 8'hDD) && have_modrm && reg_f == 3'd0:
        info = mk(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, KIND_NORM);
      b == 8'hDB && have_modrm && reg_f == 3'd5:
        info = mk(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, KIND_NORM);
      b == 8'hCC || b == 8'hC9 || b == 8'h90: info = n;
      b == 8'hEB || (b >= 8'h70 && b <= 8'h7F):
        info = mk(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, KIND_JMP);
      b == 8'hE9: info = mk(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, KIND_JMP);
      (b & PlusrMask) == 8'hB0: info = mk(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, KIND_NORM);
      (b & PlusrMask) == 8'hB8: info = mk(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, KIND_NORM);
      b == 8'hC6 && have_modrm && reg_f == 3'd0:
        info = mk(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, KIND_NORM);
      b == 8'hC7 && have_modrm && reg_f == 3'd0:
        info = mk(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, KIND_NORM);
      b == 8'h8F && have_modrm && reg_f == 3'd0:
        info = mk(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, KIND_NORM);
      b == 8'hC3: info = mk(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, KIND_RET);
      b == 8'hC2: info = mk(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, KIND_RET);
      b == 8'hF6 && have_modrm && reg_f == 3'd0:
        info = mk(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, KIND_NORM);
      b == 8'hF7 && have_modrm && reg_f == 3'd0:
        info = mk(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, KIND_NORM);
      default: info.hit = 1'b0;
    endcase
    return info;
  endfunction

endpackage : xil_pkg
`default_nettype wire

### hdl/x86_insn_length_and_branch_reloc.sv
`default_nettype none
// Three register stages (prefix, decode, reloc); an accepted item passes through the
// prefix, decode and output registers in that order before its result is valid.
// Throughput: one item per cycle while the output is not stalled; the three register stages advance together.
// A stalled output holds every stage; nothing is dropped or repeated.
// Reset clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// x86_insn_length_and_branch_reloc
// 32-bit x86 instruction length decoder with rel32 branch re-targeting.
// ----------------------------------------------------------------------------
module x86_insn_length_and_branch_reloc import xil_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] code_low_i,
  input  wire logic [55:0] code_high_i,
  input  wire logic [31:0] source_address_i,
  input  wire logic [31:0] dest_address_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             decode_ok_o,
  output logic [3:0]       total_length_o,
  output logic signed [4:0] modrm_offset_o,
  output logic signed [4:0] imm_offset_o,
  output logic [2:0]       imm_size_o,
  output logic signed [4:0] reloc_offset_o,
  output logic [2:0]       reloc_size_o,
  output logic [1:0]       insn_kind_o,
  output logic             convert_ok_o,
  output logic signed [31:0] new_rel32_o
);

  logic             en, v1, v2, v3_q;
  s1_t              s1;
  s2_t              s2;
  logic [14:0][7:0] w;
  logic [31:0]      imm, rel;
  logic [3:0]       o;
  logic             conv;

  // Advance the pipe when the output slot is free or being taken
  assign en          = !v3_q || out_ready_i;
  assign in_ready_o  = en;

  xil_prefix u_prefix (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .code_low_i, .code_high_i, .src_i(source_address_i), .dst_i(dest_address_i),
    .valid_o(v1), .item_o(s1)
  );

  xil_decode u_decode (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1), .item_i(s1),
    .valid_o(v2), .item_o(s2)
  );

  // Gather and sign-extend the immediate, then re-target
  assign w    = {s2.w_hi, s2.w_lo};
  assign o    = s2.imm_off[3:0];
  assign conv = !s2.fail && (s2.kind == KIND_JMP || s2.kind == KIND_CALL) &&
                s2.imm_size != 3'd0;
  always_comb begin
    unique case (s2.imm_size)
      3'd1:    imm = {{24{w[o][7]}}, w[o]};
      3'd2:    imm = {{16{w[o + 4'd1][7]}}, w[o + 4'd1], w[o]};
      3'd4:    imm = {w[o + 4'd3], w[o + 4'd2], w[o + 4'd1], w[o]};
      default: imm = '0;
    endcase
    rel = s2.src + {27'd0, s2.len} + imm - (s2.dst + BranchLen);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2;
  end

  // Output register; failure forces the defined empty result
  always_ff @(posedge clk_i) begin
    if (en) begin
      decode_ok_o    <= !s2.fail;
      total_length_o <= s2.fail ? 4'd0 : s2.len[3:0];
      modrm_offset_o <= s2.fail ? 5'h1F : s2.modrm_off;
      imm_offset_o   <= s2.fail ? 5'h1F : s2.imm_off;
      imm_size_o     <= s2.fail ? 3'd0 : s2.imm_size;
      reloc_offset_o <= (s2.fail || !s2.rel) ? 5'h1F : s2.imm_off;
      reloc_size_o   <= (s2.fail || !s2.rel) ? 3'd0 : s2.reloc_size;
      insn_kind_o    <= s2.fail ? KIND_NORM : s2.kind;
      convert_ok_o   <= conv;
      new_rel32_o    <= conv ? rel : 32'd0;
    end
  end

  assign out_valid_o = v3_q;

endmodule : x86_insn_length_and_branch_reloc
`default_nettype wire

### hdl/xil_prefix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xil_prefix
// Stage 1: register the window and find the first non-prefix byte.
// ----------------------------------------------------------------------------
module xil_prefix import xil_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire logic [63:0] code_low_i,
  input  wire logic [55:0] code_high_i,
  input  wire logic [31:0] src_i,
  input  wire logic [31:0] dst_i,
  output logic             valid_o,
  output s1_t              item_o
);

  logic [14:0][7:0] w;
  s1_t              item_d, item_q;
  logic             valid_q;
  logic             done;

  assign w = {code_high_i, code_low_i};

  // Scan prefixes; window bytes are independent compares feeding a priority pick
  always_comb begin
    item_d        = '0;
    item_d.w_lo   = code_low_i;
    item_d.w_hi   = code_high_i;
    item_d.src    = src_i;
    item_d.dst    = dst_i;
    item_d.fail   = 1'b1;
    done          = 1'b0;
    for (int i = 0; i < MaxInsnBytes; i++) begin
      if (!done) begin
        if (is_prefix(w[i])) begin
          if (w[i] == OpszPrefix) item_d.opsz16 = 1'b1;
        end else begin
          done        = 1'b1;
          item_d.fail = 1'b0;
          item_d.pos  = PosW'(i);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (en_i) valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule : xil_prefix
`default_nettype wire

### hdl/xil_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xil_decode
// Stage 2: match the opcode and size modrm, SIB, displacement, immediate.
// ----------------------------------------------------------------------------
module xil_decode import xil_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic valid_i,
  input  s1_t       item_i,
  output logic      valid_o,
  output s2_t       item_o
);

  logic [14:0][7:0] w;
  opinfo_t          info;
  logic [7:0]       op, m, sib;
  logic [4:0]       p, disp, immsz;
  s2_t              item_d, item_q;
  logic             valid_q;

  assign w    = {item_i.w_hi, item_i.w_lo};
  assign op   = w[item_i.pos];
  assign m    = (item_i.pos < 4'd14) ? w[item_i.pos + 4'd1] : 8'h00;
  assign sib  = (item_i.pos < 4'd13) ? w[item_i.pos + 4'd2] : 8'h00;
  assign info = match_op(op, m[5:3], item_i.pos < 4'd14);

  // Walk the fields; any overrun of the window fails the item
  always_comb begin
    item_d           = '0;
    item_d.w_lo      = item_i.w_lo;
    item_d.w_hi      = item_i.w_hi;
    item_d.src       = item_i.src;
    item_d.dst       = item_i.dst;
    item_d.modrm_off = 5'h1F;
    item_d.imm_off   = 5'h1F;
    item_d.kind      = info.kind;
    item_d.rel       = info.rel;
    item_d.fail      = item_i.fail || !info.hit;
    p                = {1'b0, item_i.pos} + 5'd1;
    disp             = '0;
    if (info.modrm) begin
      if (p + 5'd1 > 5'(MaxInsnBytes)) item_d.fail = 1'b1;
      item_d.modrm_off = p;
      p                = p + 5'd1;
      if (m[7:6] != 2'd3) begin
        if (m[2:0] == 3'd4) begin
          if (p + 5'd1 > 5'(MaxInsnBytes)) item_d.fail = 1'b1;
          p = p + 5'd1;
          if (m[7:6] == 2'd0 && sib[2:0] == 3'd5) disp = 5'd4;
        end else if (m[7:6] == 2'd0 && m[2:0] == 3'd5) begin
          disp = 5'd4;
        end
        if (m[7:6] == 2'd1) disp = 5'd1;
        if (m[7:6] == 2'd2) disp = 5'd4;
        if (p + disp > 5'(MaxInsnBytes)) item_d.fail = 1'b1;
        p = p + disp;
      end
    end
    priority if (info.i8)  immsz = 5'd1;
    else if (info.i16)     immsz = 5'd2;
    else if (info.i32)     immsz = item_i.opsz16 ? 5'd2 : 5'd4;
    else                   immsz = 5'd0;
    if (immsz != 5'd0) begin
      if (p + immsz > 5'(MaxInsnBytes)) item_d.fail = 1'b1;
      item_d.imm_off = p;
      p              = p + immsz;
    end
    item_d.imm_size = immsz[2:0];
    priority if (info.i8)  item_d.reloc_size = 3'd1;
    else if (info.i32)     item_d.reloc_size = 3'd4;
    else if (info.i16)     item_d.reloc_size = 3'd2;
    else                   item_d.reloc_size = 3'd0;
    item_d.len = p;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (en_i) valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule : xil_decode
`default_nettype wire

### hdl/xil_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xil_checker
// Port-level properties of the length decoder, bound to the top level.
// ----------------------------------------------------------------------------
module xil_checker import xil_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       decode_ok_o,
  input wire logic [3:0] total_length_o,
  input wire logic [1:0] insn_kind_o,
  input wire logic       convert_ok_o,
  input wire logic [31:0] new_rel32_o
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(new_rel32_o))
    else $error("stalled result changed");

  // Input is blocked only while the result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without stall");

  // A failed decode carries no length and no conversion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !decode_ok_o |-> total_length_o == 4'd0 && !convert_ok_o)
    else $error("failed decode not empty");

  // Conversion only for jumps and calls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && convert_ok_o |-> insn_kind_o == KIND_JMP || insn_kind_o == KIND_CALL)
    else $error("conversion on wrong kind");

endmodule : xil_checker

bind x86_insn_length_and_branch_reloc xil_checker u_xil_checker (.*);
`default_nettype wire

### test/x86_insn_length_and_branch_reloc_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_insn_length_and_branch_reloc_chk
// Watches both channels of the length decoder. For each accepted code window
// it computes the expected decode and rel32 re-target. It then compares each
// returned result, field by field and in order, against that expectation.
// ----------------------------------------------------------------------------
module x86_insn_length_and_branch_reloc_chk import xil_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [63:0] code_low_i,
  input  wire logic [55:0] code_high_i,
  input  wire logic [31:0] source_address_i,
  input  wire logic [31:0] dest_address_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic        decode_ok_i,
  input  wire logic [3:0]  total_length_i,
  input  wire logic [4:0]  modrm_offset_i,
  input  wire logic [4:0]  imm_offset_i,
  input  wire logic [2:0]  imm_size_i,
  input  wire logic [4:0]  reloc_offset_i,
  input  wire logic [2:0]  reloc_size_i,
  input  wire logic [1:0]  insn_kind_i,
  input  wire logic        convert_ok_i,
  input  wire logic [31:0] new_rel32_i,
  output int               err_cnt_o,
  output int               pending_o,
  output int               checked_o,
  output int               converted_o
);

  localparam int unsigned WinBytes = 15;

  // Opcode attribute bits
  localparam logic [7:0] FModrm = 8'h01;
  localparam logic [7:0] FPlusr = 8'h02;
  localparam logic [7:0] FRegop = 8'h04;
  localparam logic [7:0] FI8    = 8'h08;
  localparam logic [7:0] FI16   = 8'h10;
  localparam logic [7:0] FI32   = 8'h20;
  localparam logic [7:0] FRel   = 8'h80;
  localparam logic [7:0] MRI8   = FModrm | FRegop | FI8;
  localparam logic [7:0] MRI32  = FModrm | FRegop | FI32;
  localparam logic [7:0] MR     = FModrm | FRegop;
  localparam logic [7:0] J8     = FI8 | FRel;
  localparam logic [4:0] NoOff  = 5'h1F;

  typedef struct packed {
    logic [7:0] op;
    logic [2:0] reg_f;
    logic [7:0] flags;
    kind_e      kind;
  } opcode_row_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  len;
    logic [4:0]  modrm_off;
    logic [4:0]  imm_off;
    logic [2:0]  imm_size;
    logic [4:0]  reloc_off;
    logic [2:0]  reloc_size;
    kind_e       kind;
    logic        conv;
    logic [31:0] rel32;
  } decode_t;

  opcode_row_t opcodes[$];
  decode_t     decode_q[$];

  task automatic add(input logic [7:0] op, input int r, input logic [7:0] f,
                     input kind_e k);
    opcodes.push_back('{op: op, reg_f: 3'(r), flags: f, kind: k});
  endtask

  // Build the opcode table in priority order
  initial begin
    add(8'h04,0,FI8,KIND_NORM);   add(8'h05,0,FI32,KIND_NORM);  add(8'h80,0,MRI8,KIND_NORM);
    add(8'h81,0,MRI32,KIND_NORM); add(8'h83,0,MRI8,KIND_NORM);  add(8'h00,0,FModrm,KIND_NORM);
    add(8'h01,0,FModrm,KIND_NORM); add(8'h02,0,FModrm,KIND_NORM);
    add(8'h03,0,FModrm,KIND_NORM);
    add(8'h24,0,FI8,KIND_NORM);   add(8'h25,0,FI32,KIND_NORM);  add(8'h80,4,MRI8,KIND_NORM);
    add(8'h81,4,MRI32,KIND_NORM); add(8'h83,4,MRI8,KIND_NORM);  add(8'h20,0,FModrm,KIND_NORM);
    add(8'h21,0,FModrm,KIND_NORM); add(8'h22,0,FModrm,KIND_NORM);
    add(8'h23,0,FModrm,KIND_NORM);
    add(8'hE8,0,FI32|FRel,KIND_CALL); add(8'hFF,2,MR,KIND_CALL);
    add(8'h83,7,MRI8,KIND_NORM);  add(8'h39,0,FModrm,KIND_NORM); add(8'h3D,0,FI32,KIND_NORM);
    add(8'hFF,1,MR,KIND_NORM);    add(8'h48,0,FPlusr,KIND_NORM);
    add(8'hC8,0,FI16|FI8,KIND_NORM); add(8'hD9,0,MR,KIND_NORM); add(8'hDD,0,MR,KIND_NORM);
    add(8'hDB,5,MR,KIND_NORM);    add(8'hCC,0,8'h00,KIND_NORM);
    add(8'hEB,0,J8,KIND_JMP);
    for (int b = 8'h70; b <= 8'h7F; b++) add(b[7:0],0,J8,KIND_JMP);
    add(8'hE9,0,FI32|FRel,KIND_JMP); add(8'hFF,4,MR,KIND_JMP);
    add(8'h8D,0,FModrm,KIND_NORM); add(8'hC9,0,8'h00,KIND_NORM);
    add(8'h88,0,FModrm,KIND_NORM); add(8'h89,0,FModrm,KIND_NORM);
    add(8'h8A,0,FModrm,KIND_NORM); add(8'h8B,0,FModrm,KIND_NORM);
    add(8'h8C,0,FModrm,KIND_NORM); add(8'h8E,0,FModrm,KIND_NORM);
    add(8'hA0,0,FI32,KIND_NORM);  add(8'hA1,0,FI32,KIND_NORM);
    add(8'hA2,0,FI32,KIND_NORM);  add(8'hA3,0,FI32,KIND_NORM);
    add(8'hB0,0,FPlusr|FI8,KIND_NORM); add(8'hB8,0,FPlusr|FI32,KIND_NORM);
    add(8'hC6,0,MRI8,KIND_NORM);  add(8'hC7,0,MRI32,KIND_NORM); add(8'h90,0,8'h00,KIND_NORM);
    add(8'h0C,0,FI8,KIND_NORM);   add(8'h0D,0,FI32,KIND_NORM);  add(8'h80,1,MRI8,KIND_NORM);
    add(8'h81,1,MRI32,KIND_NORM); add(8'h83,1,MRI8,KIND_NORM);  add(8'h08,0,FModrm,KIND_NORM);
    add(8'h09,0,FModrm,KIND_NORM); add(8'h0A,0,FModrm,KIND_NORM);
    add(8'h0B,0,FModrm,KIND_NORM);
    add(8'h8F,0,MR,KIND_NORM);    add(8'h58,0,FPlusr,KIND_NORM); add(8'hFF,6,MR,KIND_NORM);
    add(8'h50,0,FPlusr,KIND_NORM); add(8'h6A,0,FI8,KIND_NORM);  add(8'h68,0,FI32,KIND_NORM);
    add(8'hC3,0,8'h00,KIND_RET);  add(8'hC2,0,FI16,KIND_RET);
    add(8'h2C,0,FI8,KIND_NORM);   add(8'h2D,0,FI32,KIND_NORM);  add(8'h80,5,MRI8,KIND_NORM);
    add(8'h81,5,MRI32,KIND_NORM); add(8'h83,5,MRI8,KIND_NORM);  add(8'h28,0,FModrm,KIND_NORM);
    add(8'h29,0,FModrm,KIND_NORM); add(8'h2A,0,FModrm,KIND_NORM);
    add(8'h2B,0,FModrm,KIND_NORM);
    add(8'hA8,0,FI8,KIND_NORM);   add(8'hA9,0,FI32,KIND_NORM);  add(8'hF6,0,MRI8,KIND_NORM);
    add(8'hF7,0,MRI32,KIND_NORM); add(8'h84,0,FModrm,KIND_NORM);
    add(8'h85,0,FModrm,KIND_NORM);
    add(8'h34,0,FI8,KIND_NORM);   add(8'h35,0,FI32,KIND_NORM);  add(8'h80,6,MRI8,KIND_NORM);
    add(8'h81,6,MRI32,KIND_NORM); add(8'h83,6,MRI8,KIND_NORM);  add(8'h30,0,FModrm,KIND_NORM);
    add(8'h31,0,FModrm,KIND_NORM); add(8'h32,0,FModrm,KIND_NORM);
    add(8'h33,0,FModrm,KIND_NORM);
  end

  function automatic logic legacy_prefix(input logic [7:0] b);
    case (b)
      8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65, 8'h66, 8'h67:
        return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Decode one window and work out the re-targeted branch displacement
  function automatic decode_t decode_window(input logic [119:0] win, input logic [31:0] src,
                                            input logic [31:0] dst);
    decode_t     d;
    logic [7:0]  w[WinBytes];
    int          pos;
    int          opsz;
    int          idx;
    int          disp;
    int          immsz;
    int          imm_pos;
    logic [4:0]  modrm_pos;
    logic [7:0]  b;
    logic [7:0]  m;
    logic [7:0]  flags;
    logic        hit;
    logic [31:0] v;
    d = '{ok: 1'b0, len: '0, modrm_off: NoOff, imm_off: NoOff, imm_size: '0,
          reloc_off: NoOff, reloc_size: '0, kind: KIND_NORM, conv: 1'b0, rel32: '0};
    modrm_pos = NoOff;
    for (int i = 0; i < WinBytes; i++) w[i] = win[8*i +: 8];
    pos  = 0;
    opsz = 4;
    // skip prefixes; an operand-size prefix shrinks Imm32 to two bytes
    while (pos < WinBytes && legacy_prefix(w[pos])) begin
      if (w[pos] == OpszPrefix) opsz = 2;
      pos++;
    end
    if (pos >= WinBytes) return d;
    // first table row that matches wins
    b   = w[pos];
    idx = -1;
    for (int i = 0; i < opcodes.size() && idx < 0; i++) begin
      hit = 1'b0;
      if (b == opcodes[i].op) begin
        if ((opcodes[i].flags & FRegop) != 0) begin
          if (pos + 2 > WinBytes) continue;
          hit = (w[pos+1][5:3] == opcodes[i].reg_f);
        end else begin
          hit = 1'b1;
        end
      end
      if (!hit && (opcodes[i].flags & FPlusr) != 0 && (b & PlusrMask) == opcodes[i].op)
        hit = 1'b1;
      if (hit) idx = i;
    end
    if (idx < 0) return d;
    flags = opcodes[idx].flags;
    pos++;
    // modrm, SIB and displacement
    if ((flags & FModrm) != 0) begin
      if (pos + 1 > WinBytes) return d;
      modrm_pos = pos[4:0];
      m = w[pos];
      pos++;
      disp = 0;
      if (m[7:6] != 2'd3) begin
        if (m[2:0] == 3'd4) begin
          if (pos + 1 > WinBytes) return d;
          if (m[7:6] == 2'd0 && w[pos][2:0] == 3'd5) disp = 4;
          pos++;
        end else if (m[7:6] == 2'd0 && m[2:0] == 3'd5) begin
          disp = 4;
        end
        if (m[7:6] == 2'd1) disp = 1;
        if (m[7:6] == 2'd2) disp = 4;
        if (pos + disp > WinBytes) return d;
        pos += disp;
      end
    end
    // immediate, Imm8 first
    immsz = 0;
    if ((flags & FI8) != 0) immsz = 1;
    else if ((flags & FI16) != 0) immsz = 2;
    else if ((flags & FI32) != 0) immsz = opsz;
    imm_pos = -1;
    if (immsz != 0) begin
      if (pos + immsz > WinBytes) return d;
      imm_pos   = pos;
      d.imm_off = pos[4:0];
      pos += immsz;
    end
    d.modrm_off = modrm_pos;
    if ((flags & FRel) != 0) begin
      d.reloc_off  = d.imm_off;
      d.reloc_size = ((flags & FI8) != 0) ? 3'd1 : ((flags & FI32) != 0) ? 3'd4 : 3'd2;
    end
    d.kind = opcodes[idx].kind;
    // re-target a jump or call to a 5-byte branch placed at dst
    if ((d.kind == KIND_JMP || d.kind == KIND_CALL) && immsz != 0) begin
      v = '0;
      for (int i = 0; i < immsz; i++) v[8*i +: 8] = w[(imm_pos + i) % WinBytes];
      if (immsz == 1) v = {{24{v[7]}}, v[7:0]};
      if (immsz == 2) v = {{16{v[15]}}, v[15:0]};
      d.rel32 = (src + 32'(pos) + v) - (dst + BranchLen);
      d.conv  = 1'b1;
    end
    d.ok       = 1'b1;
    d.len      = pos[3:0];
    d.imm_size = immsz[2:0];
    return d;
  endfunction

  function automatic int cmp(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  // Record accepted windows, then check returned results in order
  always @(posedge clk_i) begin
    decode_t e;
    if (rst_ni && in_valid_i && in_ready_i)
      decode_q.push_back(decode_window({code_high_i, code_low_i}, source_address_i,
                                       dest_address_i));
    if (rst_ni && out_valid_i && out_ready_i) begin
      if (decode_q.size() == 0) begin
        $error("result with no window outstanding");
        err_cnt_o <= err_cnt_o + 1;
      end else begin
        e = decode_q.pop_front();
        err_cnt_o <= err_cnt_o
          + cmp("decode_ok", 32'(e.ok), 32'(decode_ok_i))
          + cmp("total_length", 32'(e.len), 32'(total_length_i))
          + cmp("modrm_offset", 32'(e.modrm_off), 32'(modrm_offset_i))
          + cmp("imm_offset", 32'(e.imm_off), 32'(imm_offset_i))
          + cmp("imm_size", 32'(e.imm_size), 32'(imm_size_i))
          + cmp("reloc_offset", 32'(e.reloc_off), 32'(reloc_offset_i))
          + cmp("reloc_size", 32'(e.reloc_size), 32'(reloc_size_i))
          + cmp("insn_kind", 32'(e.kind), 32'(insn_kind_i))
          + cmp("convert_ok", 32'(e.conv), 32'(convert_ok_i))
          + cmp("new_rel32", e.rel32, new_rel32_i);
        checked_o <= checked_o + 1;
        if (e.conv) converted_o <= converted_o + 1;
      end
    end
    pending_o <= decode_q.size();
  end

  initial begin
    err_cnt_o   = 0;
    pending_o   = 0;
    checked_o   = 0;
    converted_o = 0;
  end

endmodule

### test/x86_insn_length_and_branch_reloc_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_insn_length_and_branch_reloc_tb
// Drives code windows into the length decoder: directed corner cases first,
// then random instructions built from prefixes, table opcodes and random
// operand bytes, mixed with raw noise. Sender and receiver idle in phases.
// ----------------------------------------------------------------------------
module x86_insn_length_and_branch_reloc_tb;
  import xil_pkg::*;

  localparam int RandItems = 600;
  localparam int CycleLimit = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] code_low_i = '0;
  logic [55:0] code_high_i = '0;
  logic [31:0] source_address_i = '0;
  logic [31:0] dest_address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        decode_ok_o;
  logic [3:0]  total_length_o;
  logic signed [4:0] modrm_offset_o;
  logic signed [4:0] imm_offset_o;
  logic [2:0]  imm_size_o;
  logic signed [4:0] reloc_offset_o;
  logic [2:0]  reloc_size_o;
  logic [1:0]  insn_kind_o;
  logic        convert_ok_o;
  logic signed [31:0] new_rel32_o;

  int err_cnt;
  int pending;
  int checked;
  int converted;
  int cycles = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int sent = 0;

  logic [7:0] pfx_bytes[11] = '{8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26,
                                8'h64, 8'h65, 8'h66, 8'h67};
  logic [7:0] op_bytes[] = '{8'h04, 8'h05, 8'h80, 8'h81, 8'h83, 8'h01, 8'h25, 8'hE8,
                             8'hFF, 8'hFF, 8'hFF, 8'h39, 8'h3D, 8'h4B, 8'hC8, 8'hD9,
                             8'hDD, 8'hDB, 8'hCC, 8'hEB, 8'h74, 8'h7F, 8'hE9, 8'hE9,
                             8'h8D, 8'hC9, 8'h8B, 8'h8E, 8'hA1, 8'hB3, 8'hBF, 8'hC6,
                             8'hC7, 8'h90, 8'h8F, 8'h5A, 8'h55, 8'h6A, 8'h68, 8'hC3,
                             8'hC2, 8'hA9, 8'hF6, 8'hF7, 8'h85, 8'h33, 8'h0F, 8'hD8};

  x86_insn_length_and_branch_reloc dut (.*);

  x86_insn_length_and_branch_reloc_chk u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .code_low_i, .code_high_i,
    .source_address_i, .dest_address_i, .out_valid_i(out_valid_o), .out_ready_i,
    .decode_ok_i(decode_ok_o), .total_length_i(total_length_o),
    .modrm_offset_i(modrm_offset_o), .imm_offset_i(imm_offset_o),
    .imm_size_i(imm_size_o), .reloc_offset_i(reloc_offset_o),
    .reloc_size_i(reloc_size_o), .insn_kind_i(insn_kind_o),
    .convert_ok_i(convert_ok_o), .new_rel32_i(new_rel32_o),
    .err_cnt_o(err_cnt), .pending_o(pending), .checked_o(checked),
    .converted_o(converted)
  );

  always #4 clk_i = ~clk_i;

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("x86_insn_length_and_branch_reloc_tb: done, errors");
      $finish;
    end
  end

  // Receiver backpressure
  always @(negedge clk_i) out_ready_i = ($urandom_range(99) >= stall_pct);

  // Offer one window and hold it until accepted
  task automatic send(input logic [119:0] win, input logic [31:0] src,
                      input logic [31:0] dst);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    code_low_i       = win[63:0];
    code_high_i      = win[119:64];
    source_address_i = src;
    dest_address_i   = dst;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic logic [119:0] rand_window();
    logic [127:0] r;
    for (int i = 0; i < 4; i++) r[32*i +: 32] = $urandom;
    return r[119:0];
  endfunction

  function automatic logic [31:0] rand_addr();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Build a window: prefixes, an opcode byte from op_bytes unless prefixes fill it, random operands
  function automatic logic [119:0] build_insn();
    logic [119:0] r;
    int np;
    r  = rand_window();
    np = ($urandom_range(19) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 3);
    for (int i = 0; i < np; i++) r[8*i +: 8] = pfx_bytes[$urandom_range(10)];
    if (np < 15) r[8*np +: 8] = op_bytes[$urandom_range(op_bytes.size() - 1)];
    return r;
  endfunction

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0 || u_chk.decode_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [119:0] w;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed corners
    send({15{8'h66}}, 32'h0, 32'h0);                               // only prefixes
    send({15{8'hF0}}, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send({120{1'b1}}, 32'hFFFF_FFFF, 32'h0);                       // all ones
    send('0, 32'h0, 32'hFFFF_FFFF);                                // add, modrm 00
    send({80'h0, 32'h1234_5678, 8'hE9}, 32'h1000, 32'h2000);        // jmp rel32
    send({80'h0, 32'h8000_0000, 8'hE8}, 32'h0, 32'hFFFF_FFFF);      // call rel32
    send({104'h0, 8'h80, 8'hEB}, 32'h10, 32'h20);                   // short jmp back
    send({80'h0, 8'h7F, 16'hFFFE, 8'hE9, 8'h66}, 32'h400, 32'h300); // jmp rel16
    send({88'h0, 8'h01, 16'h0010, 8'hC8}, 32'h0, 32'h0);            // enter
    send({96'h0, 16'h0008, 8'hC2}, 32'h0, 32'h0);                   // ret imm16
    send({112'h0, 8'hC3}, 32'h0, 32'h0);                            // ret
    send({64'h0, 32'hDEAD_BEEF, 8'h05, 8'hC7, 8'h66}, 32'h0, 32'h0);  // mov imm16
    send({112'h0, 8'h0F}, 32'h0, 32'h0);                            // no match
    send({8'hFF, {14{8'h2E}}}, 32'h0, 32'h0);                       // /r row cut off
    send({8'h48, {14{8'h2E}}}, 32'h0, 32'h0);                       // +r at last byte
    send({8'h04, {14{8'h2E}}}, 32'h0, 32'h0);                       // imm cut off
    send({8'h24, 8'h8B, {13{8'h3E}}}, 32'h0, 32'h0);                // SIB cut off
    send({16'h0, 8'h05, 8'h8B, {11{8'h36}}}, 32'h0, 32'h0);         // disp32 cut off
    send({96'h0, 8'h25, 8'h04, 8'h8B}, 32'h0, 32'h0);               // SIB, base 5
    send({80'h0, 32'h0000_0000, 8'hA0}, 32'h0, 32'h0);
    send({104'h0, 8'h15, 8'hFF}, 32'h0, 32'h0);                     // call [disp32]
    send({104'h0, 8'hE0, 8'hFF}, 32'h0, 32'h0);                     // jmp reg
    send({104'h0, 8'hD0, 8'hFF}, 32'hFFFF_FFF0, 32'h0);             // call reg
    send({104'h0, 8'h38, 8'h80}, 32'h0, 32'h0);                     // 80 /7 unmatched

    // random phases of idling; halfway through, drain before going on
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 52; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 52; end
        default: begin gap_pct = 27; stall_pct = 27; end
      endcase
      for (int n = 0; n < RandItems / 4; n++) begin
        w = ($urandom_range(9) < 8) ? build_insn() : rand_window();
        send(w, rand_addr(), rand_addr());
      end
      if (ph == 1) begin
        drop_valid();
        wait_drained();
      end
    end
    drop_valid();

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d windows, checked %0d results, %0d branch re-targets.",
             sent, checked, converted);
    if (err_cnt == 0) begin
      $display("x86_insn_length_and_branch_reloc_tb: done, clean");
    end else begin
      $display("x86_insn_length_and_branch_reloc_tb: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/xil_pkg.sv
hdl/xil_prefix.sv
hdl/xil_decode.sv
hdl/x86_insn_length_and_branch_reloc.sv
hdl/xil_checker.sv
test/x86_insn_length_and_branch_reloc_chk.sv
test/x86_insn_length_and_branch_reloc_tb.sv
